// File: sv/rtbah_pkg.sv
package rtbah_pkg;

    // Default number of entries in the unacknowledged segment table.
    localparam int TABLE_DEPTH_DEF = 16;

    // Field widths.
    localparam int ACT_W  = 2;
    localparam int KIND_W = 3;
    localparam int SEQ_W  = 32;
    localparam int TAG_W  = 16;

    // Request actions.
    localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEND    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ACK     = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] K_STARTED   = 3'd0;
    localparam logic [KIND_W-1:0] K_SENT      = 3'd1;
    localparam logic [KIND_W-1:0] K_RESENT    = 3'd2;
    localparam logic [KIND_W-1:0] K_ACKED     = 3'd3;
    localparam logic [KIND_W-1:0] K_TIMEOUT   = 3'd4;
    localparam logic [KIND_W-1:0] K_BADACK    = 3'd5;
    localparam logic [KIND_W-1:0] K_NOTFOUND  = 3'd6;
    localparam logic [KIND_W-1:0] K_FULLEMPTY = 3'd7;

    // One input request, unpacked from the stream.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [TAG_W-1:0] payload_tag;
        logic             payload_empty;
        logic             ack_bit;
        logic [SEQ_W-1:0] peer_seq;
        logic [SEQ_W-1:0] peer_ack;
    } t_in_item;

    // One result, before packing onto the stream.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seg_seq;
        logic [SEQ_W-1:0]  seg_ack;
        logic [TAG_W-1:0]  seg_payload;
        logic              final_mark;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted request
        logic scan_start;  // rewind the table scan
        logic scan_step;   // read one table entry
        logic finish;      // commit state and load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;   // the captured request has to walk the table
        logic scan_last;   // the scan address is at the last entry
        logic out_busy;    // the result register holds a result not yet taken
    } t_sts;

endpackage

// File: sv/rtbah_ctrl.sv
module rtbah_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  rtbah_pkg::t_sts i_sts,
    output logic            o_in_ready,
    output rtbah_pkg::t_cmd o_cmd
);
    import rtbah_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_LAST   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.need_scan) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                // The last entry read is compared in this cycle.
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/rtbah_dp.sv
module rtbah_dp #(
    parameter int TABLE_DEPTH = rtbah_pkg::TABLE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rtbah_pkg::t_in_item  i_item,
    input  rtbah_pkg::t_cmd      i_cmd,
    input  logic                 i_out_ready,
    output rtbah_pkg::t_sts      o_sts,
    output logic                 o_out_valid,
    output rtbah_pkg::t_out_item o_out_item
);
    import rtbah_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    // Captured request.
    logic [ACT_W-1:0] r_action;
    logic [TAG_W-1:0] r_tag;
    logic             r_fin;
    logic             r_ackb;
    logic [SEQ_W-1:0] r_pseq;
    logic [SEQ_W-1:0] r_pack;

    // Connection state.
    logic [SEQ_W-1:0] r_next_seq;
    logic [SEQ_W-1:0] r_ack_to_send;

    // Segment table: valid bits in flops, contents in memory.
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [SEQ_W-1:0]       mem_seq [TABLE_DEPTH];
    logic [TAG_W-1:0]       mem_pay [TABLE_DEPTH];

    // Scan address and read pipeline.
    logic [AW:0]      r_addr;
    logic             r_rd_vld;
    logic [AW-1:0]    r_rd_idx;
    logic [SEQ_W-1:0] r_rd_seq;
    logic [TAG_W-1:0] r_rd_pay;

    // Scan findings.
    logic             r_hit;
    logic [TAG_W-1:0] r_hit_pay;
    logic             r_free_found;
    logic [AW-1:0]    r_free_idx;
    logic             r_any;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;

    logic [SEQ_W-1:0] w_key;
    logic             w_ent_v;
    logic             w_match;
    logic             w_cum;
    logic             w_drop;
    logic [SEQ_W-1:0] w_ack_new;
    t_out_item        w_res;
    logic             w_store;
    logic             w_advance;

    // Capture the request when it is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_item.action;
            r_tag    <= i_item.payload_tag;
            r_fin    <= i_item.payload_empty;
            r_ackb   <= i_item.ack_bit;
            r_pseq   <= i_item.peer_seq;
            r_pack   <= i_item.peer_ack;
        end
    end

    // Compare of the entry that came back from the memory.
    assign w_key     = (r_action == ACT_SEND) ? r_next_seq : r_pack;
    assign w_ent_v   = r_valid[r_rd_idx];
    assign w_match   = r_rd_vld && w_ent_v && (r_rd_seq == w_key);
    assign w_cum     = (r_pack == r_next_seq);
    assign w_drop    = r_rd_vld && w_ent_v && (r_action == ACT_ACK) && r_ackb
                       && w_cum && (r_rd_seq < r_pack);
    assign w_ack_new = r_pseq + SEQ_W'(1);

    // Scan address counter and read pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.scan_start) begin
                r_addr <= '0;
            end else if (i_cmd.scan_step) begin
                r_addr <= r_addr + (AW+1)'(1);
            end
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            mem_seq[r_free_idx] <= r_next_seq;
            mem_pay[r_free_idx] <= r_tag;
        end
        if (i_cmd.scan_step) begin
            r_rd_seq <= mem_seq[r_addr[AW-1:0]];
            r_rd_pay <= mem_pay[r_addr[AW-1:0]];
            r_rd_idx <= r_addr[AW-1:0];
        end
    end

    // Gather the first match, the lowest free entry and any valid entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_any        <= 1'b0;
        end else if (r_rd_vld) begin
            if (w_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_pay <= r_rd_pay;
            end
            if (!w_ent_v && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
            if (w_ent_v) begin
                r_any <= 1'b1;
            end
        end
    end

    // Result and state changes for the finished request.
    always_comb begin
        w_res     = '0;
        w_store   = 1'b0;
        w_advance = 1'b0;
        unique case (r_action)
            ACT_START: begin
                w_res.kind    = K_STARTED;
                w_res.seg_seq = SEQ_W'(1);
                w_res.seg_ack = r_ack_to_send;
            end
            ACT_SEND: begin
                w_res.seg_seq     = r_next_seq;
                w_res.seg_ack     = r_ack_to_send;
                w_res.seg_payload = r_tag;
                w_res.final_mark  = r_fin;
                if (r_hit || r_free_found) begin
                    w_res.kind = K_SENT;
                    w_store    = i_cmd.finish && !r_hit;
                    w_advance  = i_cmd.finish;
                end else begin
                    w_res.kind = K_FULLEMPTY;
                end
            end
            ACT_ACK: begin
                w_res.seg_seq = r_pack;
                w_res.seg_ack = w_ack_new;
                priority if (!r_ackb) begin
                    w_res.kind = K_BADACK;
                end else if (!r_any) begin
                    w_res.kind = K_FULLEMPTY;
                end else if (w_cum) begin
                    w_res.kind = K_ACKED;
                end else if (r_hit) begin
                    w_res.kind        = K_RESENT;
                    w_res.seg_payload = r_hit_pay;
                end else begin
                    w_res.kind = K_NOTFOUND;
                end
            end
            ACT_TIMEOUT: begin
                w_res.kind = K_TIMEOUT;
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    // Sequence numbers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seq    <= '0;
            r_ack_to_send <= '0;
        end else if (i_cmd.finish) begin
            if (r_action == ACT_START) begin
                r_next_seq <= SEQ_W'(1);
            end else if (w_advance) begin
                r_next_seq <= r_next_seq + SEQ_W'(1);
            end
            if (r_action == ACT_ACK) begin
                r_ack_to_send <= w_ack_new;
            end
        end
    end

    // Valid bits: cleared by start, set by a store, dropped by a cumulative ack.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.finish && (r_action == ACT_START)) begin
                r_valid <= '0;
            end else if (w_store) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (w_drop) begin
                r_valid[r_rd_idx] <= 1'b0;
            end
        end
    end

    // Result register; a new result only loads once the old one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= w_res;
        end
    end

    assign o_sts.need_scan = (r_action == ACT_SEND) || ((r_action == ACT_ACK) && r_ackb);
    assign o_sts.scan_last = (r_addr == (AW+1)'(TABLE_DEPTH-1));
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out;

endmodule

// File: sv/retransmit_buffer_ack_handler.sv
// Channel   Direction  Handshake                Payload
// request   in         i_s_tvalid / o_s_tready  i_s_tdata, i_s_tuser, i_s_tlast
// result    out        o_m_tvalid / i_m_tready  o_m_tdata, o_m_tuser, o_m_tlast
//
// Start, timeout and bad-ack requests skip the table and go from DECIDE to FINISH.
// Send and ack requests walk the table one entry a cycle through the memory's
// registered read port, then pass through LAST to FINISH.
// One request is in work at a time; a new one is accepted while the previous
// result still waits in the output register.
// Reset clears the sequence numbers and all valid bits.
// A stalled result holds the block in its final step until it is taken.
module retransmit_buffer_ack_handler #(
    parameter int TABLE_DEPTH = rtbah_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // payload_tag[15:0], ack_bit[16], peer_seq[48:17], peer_ack[80:49], zero fill
    input  logic [87:0] i_s_tdata,
    // action[1:0]
    input  logic [1:0]  i_s_tuser,
    // payload_empty
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // seg_seq[31:0], seg_ack[63:32], seg_payload[79:64]
    output logic [79:0] o_m_tdata,
    // kind[2:0]
    output logic [2:0]  o_m_tuser,
    // final_mark
    output logic        o_m_tlast
);
    import rtbah_pkg::*;

    t_in_item  w_item;
    t_out_item w_out;
    t_cmd      w_cmd;
    t_sts      w_sts;

    // Unpack the request stream.
    assign w_item.action        = i_s_tuser;
    assign w_item.payload_tag   = i_s_tdata[15:0];
    assign w_item.ack_bit       = i_s_tdata[16];
    assign w_item.peer_seq      = i_s_tdata[48:17];
    assign w_item.peer_ack      = i_s_tdata[80:49];
    assign w_item.payload_empty = i_s_tlast;

    rtbah_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_sts      (w_sts),
        .o_in_ready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    rtbah_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .i_out_ready (i_m_tready),
        .o_sts       (w_sts),
        .o_out_valid (o_m_tvalid),
        .o_out_item  (w_out)
    );

    // Pack the result stream.
    assign o_m_tdata = {w_out.seg_payload, w_out.seg_ack, w_out.seg_seq};
    assign o_m_tuser = w_out.kind;
    assign o_m_tlast = w_out.final_mark;

`ifndef SYNTHESIS
    // A result is committed only into a free output register.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> !w_sts.out_busy)
        else $error("result committed over a pending result");

    // A committed result shows on the output in the next cycle.
    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_m_tvalid)
        else $error("committed result not presented");

    // Only one request is in work: none is taken right after another.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while another is in work");

    // No request is accepted during a table scan.
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_step |-> !o_s_tready)
        else $error("ready raised during table scan");
`endif

endmodule
